>>> hdl/mfa_pkg.sv
// shared types and constants for the metaball field accumulator
package mfa_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 8'd1;

  localparam logic [14:0] RADIUS_RST   = 15'd410;
  localparam logic [15:0] STRENGTH_RST = 16'd256;

  // last step index of the bit-serial multiplies and of the divider
  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHECK,
    ST_SR,
    ST_DVL,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } mfa_state_e;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic sr_step;
    logic div_load;
    logic div_step;
  } mfa_ctrl_t;

endpackage

>>> hdl/mfa_mul.sv
// bit-serial squares of dx, dy and radius, then strength times radius squared
module mfa_mul (
  input  logic                     clk_i,
  input  mfa_pkg::mfa_ctrl_t       ctrl_i,
  input  logic signed [15:0]       point_x_i,
  input  logic signed [15:0]       point_y_i,
  input  logic signed [15:0]       particle_x_i,
  input  logic signed [15:0]       particle_y_i,
  input  logic        [14:0]       radius_i,
  input  logic        [15:0]       strength_i,
  output logic        [32:0]       d2_o,
  output logic        [29:0]       r2_o,
  output logic        [45:0]       prod_o
);

  logic [16:0] dx, dy;
  logic [15:0] adx, ady;

  logic [15:0] ax_q, ay_q, mx_q, my_q, mr_q, ms_q;
  logic [14:0] ar_q;
  logic [31:0] accx_q, accy_q;
  logic [29:0] accr_q;
  logic [45:0] accp_q;

  assign dx  = {point_x_i[15], point_x_i} - {particle_x_i[15], particle_x_i};
  assign dy  = {point_y_i[15], point_y_i} - {particle_y_i[15], particle_y_i};
  // magnitude of a 17-bit difference always fits in 16 bits
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ax_q   <= adx;
      mx_q   <= adx;
      ay_q   <= ady;
      my_q   <= ady;
      ar_q   <= radius_i;
      mr_q   <= {1'b0, radius_i};
      ms_q   <= strength_i;
      accx_q <= '0;
      accy_q <= '0;
      accr_q <= '0;
      accp_q <= '0;
    end else if (ctrl_i.sq_step) begin
      // msb first: acc = 2*acc + bit*multiplicand
      accx_q <= {accx_q[30:0], 1'b0} + (mx_q[15] ? {16'b0, ax_q} : 32'd0);
      accy_q <= {accy_q[30:0], 1'b0} + (my_q[15] ? {16'b0, ay_q} : 32'd0);
      accr_q <= {accr_q[28:0], 1'b0} + (mr_q[15] ? {15'b0, ar_q} : 30'd0);
      mx_q   <= {mx_q[14:0], 1'b0};
      my_q   <= {my_q[14:0], 1'b0};
      mr_q   <= {mr_q[14:0], 1'b0};
    end else if (ctrl_i.sr_step) begin
      accp_q <= {accp_q[44:0], 1'b0} + (ms_q[15] ? {16'b0, accr_q} : 46'd0);
      ms_q   <= {ms_q[14:0], 1'b0};
    end
  end

  assign d2_o   = {1'b0, accx_q} + {1'b0, accy_q};
  assign r2_o   = accr_q;
  assign prod_o = accp_q;

endmodule

>>> hdl/mfa_div.sv
// radix-2 restoring divider for the influence term, with quotient overflow detect
module mfa_div (
  input  logic               clk_i,
  input  mfa_pkg::mfa_ctrl_t ctrl_i,
  input  logic [45:0]        prod_i,
  input  logic [29:0]        d2_i,
  output logic [31:0]        term_o,
  output logic               too_big_o
);

  logic [29:0] rem_q, dvs_q;
  logic [31:0] quo_q;
  logic        too_big_q;
  logic [30:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      // numerator is prod * 2^8; its part above bit 31 decides overflow
      rem_q     <= {8'b0, prod_i[45:24]};
      quo_q     <= {prod_i[23:0], 8'b0};
      dvs_q     <= d2_i;
      too_big_q <= {8'b0, prod_i[45:24]} >= d2_i;
    end else if (ctrl_i.div_step) begin
      rem_q <= fits ? 30'(trial - {1'b0, dvs_q}) : trial[29:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

  assign term_o    = too_big_q ? 32'hFFFF_FFFF : quo_q;
  assign too_big_o = too_big_q;

endmodule

>>> hdl/metaball_field_accumulator_unit.sv
// top level: metaball field accumulator with serial multiply and divide
//
// s_axis carries one item per grid point and particle pair: tdata holds the
// coordinates, tuser the particle valid flag and tlast the last particle mark.
// m_axis gives one item per grid point, on the item marked last: tdata the
// Q16.16 field sum, tuser the saturation flag.
// cfg carries register writes (index 0 radius, index 1 strength), always
// ready; indexes beyond these are dropped.
// An item whose particle is invalid skips all arithmetic; one that lies out of
// range or on the point runs only the squares; one that contributes runs two
// 16-step bit-serial multiply passes and a 32-step radix-2 divide.
// A result leaves through an output register; while the receiver stalls the
// block keeps accepting items and only holds on a further last item until the
// register is taken.
// Reset clears the running sum, the flag and the output valid, and restores the
// register defaults (radius 410, strength 256).
module metaball_field_accumulator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // point_x, point_y, particle_x, particle_y
  input  logic        s_axis_tuser_i,  // particle_valid
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // field_value
  output logic        m_axis_tuser_o,  // saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mfa_pkg::mfa_state_e state_q, state_d;
  mfa_pkg::mfa_ctrl_t  ctrl;

  logic [4:0]  cnt_q, cnt_d;
  logic [14:0] radius_q;
  logic [15:0] strength_q;
  logic        last_q;
  logic [31:0] sum_q, sum_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q;
  logic        out_sat_q;
  logic        out_load;

  logic [32:0] d2;
  logic [29:0] r2;
  logic [45:0] prod;
  logic [31:0] term;
  logic        too_big;
  logic [32:0] sum_ext;
  logic        accept;

  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  mfa_mul u_mul (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .point_x_i    (s_axis_tdata_i[15:0]),
    .point_y_i    (s_axis_tdata_i[31:16]),
    .particle_x_i (s_axis_tdata_i[47:32]),
    .particle_y_i (s_axis_tdata_i[63:48]),
    .radius_i     (radius_q),
    .strength_i   (strength_q),
    .d2_o         (d2),
    .r2_o         (r2),
    .prod_o       (prod)
  );

  mfa_div u_div (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .prod_i    (prod),
    .d2_i      (d2[29:0]),
    .term_o    (term),
    .too_big_o (too_big)
  );

  assign sum_ext = {1'b0, sum_q} + {1'b0, term};

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    ctrl            = '0;
    sum_d           = sum_q;
    ovf_d           = ovf_q;
    out_load        = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      mfa_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          state_d   = s_axis_tuser_i ? mfa_pkg::ST_SQ : mfa_pkg::ST_FIN;
        end
      end
      mfa_pkg::ST_SQ: begin
        ctrl.sq_step = 1'b1;
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == mfa_pkg::MUL_LAST) state_d = mfa_pkg::ST_CHECK;
      end
      mfa_pkg::ST_CHECK: begin
        cnt_d = '0;
        // only 0 < d2 < r2 contributes
        if (d2 != '0 && d2 < {3'b0, r2}) state_d = mfa_pkg::ST_SR;
        else                             state_d = mfa_pkg::ST_FIN;
      end
      mfa_pkg::ST_SR: begin
        ctrl.sr_step = 1'b1;
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == mfa_pkg::MUL_LAST) state_d = mfa_pkg::ST_DVL;
      end
      mfa_pkg::ST_DVL: begin
        ctrl.div_load = 1'b1;
        cnt_d         = '0;
        state_d       = mfa_pkg::ST_DIV;
      end
      mfa_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q == mfa_pkg::DIV_LAST) state_d = mfa_pkg::ST_ACC;
      end
      mfa_pkg::ST_ACC: begin
        sum_d   = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        ovf_d   = ovf_q || too_big || sum_ext[32];
        state_d = mfa_pkg::ST_FIN;
      end
      mfa_pkg::ST_FIN: begin
        if (!last_q) begin
          state_d = mfa_pkg::ST_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          sum_d    = '0;
          ovf_d    = 1'b0;
          state_d  = mfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (out_load)        out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfa_pkg::ST_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      radius_q    <= mfa_pkg::RADIUS_RST;
      strength_q  <= mfa_pkg::STRENGTH_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mfa_pkg::REG_RADIUS:   radius_q   <= cfg_data_i[14:0];
          mfa_pkg::REG_STRENGTH: strength_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) last_q <= s_axis_tlast_i;
    if (out_load) begin
      out_value_q <= sum_q;
      out_sat_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_sat_q;

endmodule

>>> hdl/mfa_checker.sv
// port-level checks for the metaball field accumulator, bound to the top level
module mfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // the input side is busy in the cycle after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready straight after an accepted item");

  // a new result only appears after the input side was busy finishing an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without an item in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

endmodule

bind metaball_field_accumulator_unit mfa_checker u_mfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
